// ===== rtl/tcpu_pkg.sv =====
package tcpu_pkg;

    // Input action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_EXEC  = 2'd1;
    localparam logic [1:0] ACT_HALT  = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_HALT       = 3'd1;
    localparam logic [2:0] STAT_INVALID    = 3'd2;
    localparam logic [2:0] STAT_PROTECTED  = 3'd3;
    localparam logic [2:0] STAT_NO_PROGRAM = 3'd4;

    // Instruction opcodes
    localparam logic [3:0] OP_LOAD_MEM = 4'h1;
    localparam logic [3:0] OP_LOAD_IMM = 4'h2;
    localparam logic [3:0] OP_STORE    = 4'h3;
    localparam logic [3:0] OP_MOVE     = 4'h4;
    localparam logic [3:0] OP_ADD      = 4'h5;
    localparam logic [3:0] OP_JUMP_EQ  = 4'hB;
    localparam logic [3:0] OP_HALT     = 4'hC;

    // Configuration register indexes and reset values
    localparam logic CFG_PROG_START = 1'b0;
    localparam logic CFG_PROG_END   = 1'b1;
    localparam logic [7:0] PROG_START_RST = 8'd16;
    localparam logic [7:0] PROG_END_RST   = 8'd16;

    // Register holding the compare value for jump-if-equal
    localparam logic [3:0] REG_ZERO = 4'd0;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] address;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic [7:0]  pc_now;
        logic [15:0] instr_now;
    } out_item_t;

    // Classified command passed from front to back
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_EXEC,
        CMD_HALT,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] address;
        logic [7:0] data;
    } cmd_t;

endpackage

// ===== rtl/eight_bit_teaching_cpu_step_core.sv =====
// Eight-bit teaching processor, one step per input item, always one result item per input.
// A front queue of QUEUE_DEPTH entries (2 or more) takes items while the back end works or
// waits on m_ready. The back end reads the 256-byte memory and the one-read-port register
// file once per cycle, which sets the order: a byte write, a halt or an unused action goes
// from idle to the result; an execute fetches two bytes and executes, with a second execute
// state for add and jump-if-equal. Memory and registers clear at once by per-entry valid flags,
// so reset and halt need no clearing pass. Write prog_start and prog_end only while idle.
module eight_bit_teaching_cpu_step_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcpu_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcpu_pkg::out_item_t m_data
);

    logic [7:0]     prog_start_reg;
    logic [7:0]     prog_end_reg;
    logic           cmd_valid, cmd_ready;
    tcpu_pkg::cmd_t cmd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_start_reg <= tcpu_pkg::PROG_START_RST;
            prog_end_reg   <= tcpu_pkg::PROG_END_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == tcpu_pkg::CFG_PROG_START) begin
                prog_start_reg <= cfg_wdata;
            end
            if (cfg_index == tcpu_pkg::CFG_PROG_END) begin
                prog_end_reg <= cfg_wdata;
            end
        end
    end

    tcpu_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tcpu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prog_start (prog_start_reg),
        .prog_end   (prog_end_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== rtl/tcpu_front.sv =====
module tcpu_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcpu_pkg::in_item_t s_data,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output tcpu_pkg::cmd_t     cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tcpu_pkg::cmd_t   queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    tcpu_pkg::cmd_t   cmd_in;
    logic             push, pop;

    // Classify the incoming item
    always_comb begin
        cmd_in.address = s_data.address;
        cmd_in.data    = s_data.data;
        case (s_data.action)
            tcpu_pkg::ACT_WRITE: cmd_in.kind = tcpu_pkg::CMD_WRITE;
            tcpu_pkg::ACT_EXEC:  cmd_in.kind = tcpu_pkg::CMD_EXEC;
            tcpu_pkg::ACT_HALT:  cmd_in.kind = tcpu_pkg::CMD_HALT;
            default:             cmd_in.kind = tcpu_pkg::CMD_NOP;
        endcase
    end

    assign s_ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified item
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/tcpu_back.sv =====
module tcpu_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          prog_start,
    input  logic [7:0]          prog_end,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  tcpu_pkg::cmd_t      cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output tcpu_pkg::out_item_t m_data
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_FETCH_HI = 6'b000010,
        ST_FETCH_LO = 6'b000100,
        ST_EXEC     = 6'b001000,
        ST_EXEC2    = 6'b010000,
        ST_OUT      = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [7:0]          pc_reg, pc_next;
    logic [7:0]          hi_reg, hi_next;
    logic [15:0]         ir_reg, ir_next;
    logic [7:0]          a_reg, a_next;
    tcpu_pkg::out_item_t res_reg, res_next;

    // Main memory: one write and one registered read per cycle
    logic [7:0]   mem [256];
    logic [255:0] mem_vld_reg;
    logic [7:0]   mem_rd_reg;
    logic         mem_rd_vld_reg;
    logic [7:0]   mem_raddr, mem_waddr, mem_wdata, mem_byte;
    logic         mem_we;

    // Register file: one write and one registered read per cycle
    logic [7:0]   rf [16];
    logic [15:0]  rf_vld_reg;
    logic [7:0]   rf_rd_reg;
    logic         rf_rd_vld_reg;
    logic [3:0]   rf_raddr, rf_waddr;
    logic [7:0]   rf_wdata, rf_byte;
    logic         rf_we;

    logic         clear;

    // Entries never written since the last clear read as zero
    assign mem_byte = mem_rd_vld_reg ? mem_rd_reg : 8'd0;
    assign rf_byte  = rf_rd_vld_reg ? rf_rd_reg : 8'd0;

    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = res_reg;

    // Sequence one command
    always_comb begin
        logic [3:0] op, r, t;
        logic [7:0] xy;
        logic [3:0] fop;

        op  = ir_reg[15:12];
        r   = ir_reg[11:8];
        t   = ir_reg[3:0];
        xy  = ir_reg[7:0];
        fop = hi_reg[7:4];

        state_next = state_reg;
        pc_next    = pc_reg;
        hi_next    = hi_reg;
        ir_next    = ir_reg;
        a_next     = a_reg;
        res_next   = res_reg;
        cmd_ready  = 1'b0;
        mem_raddr  = pc_reg;
        mem_we     = 1'b0;
        mem_waddr  = cmd.address;
        mem_wdata  = cmd.data;
        rf_raddr   = r;
        rf_we      = 1'b0;
        rf_waddr   = r;
        rf_wdata   = mem_byte;
        clear      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                cmd_ready          = 1'b1;
                res_next.out_valid = 1'b0;
                res_next.out_byte  = 8'd0;
                res_next.status    = tcpu_pkg::STAT_OK;
                res_next.pc_now    = pc_reg;
                res_next.instr_now = 16'd0;
                if (cmd_valid) begin
                    state_next = ST_OUT;
                    case (cmd.kind)
                        tcpu_pkg::CMD_WRITE: begin
                            mem_we = 1'b1;
                        end
                        tcpu_pkg::CMD_HALT: begin
                            clear           = 1'b1;
                            pc_next         = prog_start;
                            res_next.status = tcpu_pkg::STAT_HALT;
                            res_next.pc_now = prog_start;
                        end
                        tcpu_pkg::CMD_EXEC: begin
                            state_next = ST_FETCH_HI;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FETCH_HI: begin
                if (mem_byte == 8'd0) begin
                    clear           = 1'b1;
                    pc_next         = prog_start;
                    res_next.status = tcpu_pkg::STAT_NO_PROGRAM;
                    res_next.pc_now = prog_start;
                    state_next      = ST_OUT;
                end else begin
                    hi_next    = mem_byte;
                    mem_raddr  = 8'(pc_reg + 8'd1);
                    state_next = ST_FETCH_LO;
                end
            end

            ST_FETCH_LO: begin
                // Latch the word, fetch the XY operand byte and first register
                ir_next   = {hi_reg, mem_byte};
                pc_next   = 8'(pc_reg + 8'd2);
                mem_raddr = mem_byte;
                if (fop == tcpu_pkg::OP_MOVE || fop == tcpu_pkg::OP_ADD) begin
                    rf_raddr = mem_byte[7:4];
                end else begin
                    rf_raddr = hi_reg[3:0];
                end
                state_next = ST_EXEC;
            end

            ST_EXEC: begin
                res_next.instr_now = ir_reg;
                res_next.pc_now    = pc_reg;
                state_next         = ST_OUT;
                case (op)
                    tcpu_pkg::OP_LOAD_MEM: begin
                        rf_we = 1'b1;
                    end
                    tcpu_pkg::OP_LOAD_IMM: begin
                        rf_we    = 1'b1;
                        rf_wdata = xy;
                    end
                    tcpu_pkg::OP_STORE: begin
                        if (xy == 8'd0) begin
                            res_next.out_valid = 1'b1;
                            res_next.out_byte  = rf_byte;
                        end else if (xy > prog_start && xy < prog_end) begin
                            clear           = 1'b1;
                            pc_next         = prog_start;
                            res_next.status = tcpu_pkg::STAT_PROTECTED;
                            res_next.pc_now = prog_start;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = xy;
                            mem_wdata = rf_byte;
                        end
                    end
                    tcpu_pkg::OP_MOVE: begin
                        rf_we    = 1'b1;
                        rf_waddr = t;
                        rf_wdata = rf_byte;
                    end
                    tcpu_pkg::OP_ADD: begin
                        a_next     = rf_byte;
                        rf_raddr   = t;
                        state_next = ST_EXEC2;
                    end
                    tcpu_pkg::OP_JUMP_EQ: begin
                        a_next     = rf_byte;
                        rf_raddr   = tcpu_pkg::REG_ZERO;
                        state_next = ST_EXEC2;
                    end
                    tcpu_pkg::OP_HALT: begin
                        clear           = 1'b1;
                        pc_next         = prog_start;
                        res_next.status = tcpu_pkg::STAT_HALT;
                        res_next.pc_now = prog_start;
                    end
                    default: begin
                        clear           = 1'b1;
                        pc_next         = prog_start;
                        res_next.status = tcpu_pkg::STAT_INVALID;
                        res_next.pc_now = prog_start;
                    end
                endcase
            end

            ST_EXEC2: begin
                // Second register operand is ready
                if (op == tcpu_pkg::OP_ADD) begin
                    rf_we    = 1'b1;
                    rf_wdata = 8'(a_reg + rf_byte);
                end else if (a_reg == rf_byte) begin
                    pc_next = xy;
                end
                res_next.pc_now = pc_next;
                state_next      = ST_OUT;
            end

            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= tcpu_pkg::PROG_START_RST;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg  <= hi_next;
        ir_reg  <= ir_next;
        a_reg   <= a_next;
        res_reg <= res_next;
    end

    // Valid flags: drop all at once on reset and on every clear
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            mem_vld_reg <= '0;
            rf_vld_reg  <= '0;
        end else begin
            if (mem_we) begin
                mem_vld_reg[mem_waddr] <= 1'b1;
            end
            if (rf_we) begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
        end
    end

    // Memory arrays
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg     <= mem[mem_raddr];
        mem_rd_vld_reg <= mem_vld_reg[mem_raddr] && !clear;
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf[rf_waddr] <= rf_wdata;
        end
        rf_rd_reg     <= rf[rf_raddr];
        rf_rd_vld_reg <= rf_vld_reg[rf_raddr] && !clear;
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;

    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_index;
    logic [7:0]          cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    tcpu_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    tcpu_pkg::out_item_t m_data;

    eight_bit_teaching_cpu_step_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the machine and its program window
    logic [7:0]  shadow_regs [16];
    logic [7:0]  shadow_mem [256];
    logic [7:0]  shadow_pc;
    logic [7:0]  win_start;
    logic [7:0]  win_end;

    tcpu_pkg::out_item_t step_results_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int checked_count = 0;
    int output_count  = 0;
    int fault_count   = 0;
    int fail_count    = 0;
    int stall_cycles  = 0;

    // Wipe registers and memory, return to the program start
    function automatic void clear_machine();
        foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
        foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
        shadow_pc = win_start;
    endfunction

    // Advance the shadow machine by one item and return the step it reports
    function automatic tcpu_pkg::out_item_t cpu_step(input tcpu_pkg::in_item_t item);
        tcpu_pkg::out_item_t res;
        logic [15:0] word;
        logic [7:0]  next_pc;
        logic [3:0]  op, ra, rs, rt;
        logic [7:0]  xy;
        res  = '0;
        word = 16'h0000;
        case (item.action)
            tcpu_pkg::ACT_WRITE: shadow_mem[item.address] = item.data;
            tcpu_pkg::ACT_HALT: begin
                clear_machine();
                res.status = tcpu_pkg::STAT_HALT;
            end
            tcpu_pkg::ACT_EXEC: begin
                if (shadow_mem[shadow_pc] == 8'h00) begin
                    clear_machine();
                    res.status = tcpu_pkg::STAT_NO_PROGRAM;
                end else begin
                    next_pc   = shadow_pc + 8'd1;
                    word      = {shadow_mem[shadow_pc], shadow_mem[next_pc]};
                    shadow_pc = shadow_pc + 8'd2;
                    op = word[15:12];
                    ra = word[11:8];
                    rs = word[7:4];
                    rt = word[3:0];
                    xy = word[7:0];
                    case (op)
                        tcpu_pkg::OP_LOAD_MEM: shadow_regs[ra] = shadow_mem[xy];
                        tcpu_pkg::OP_LOAD_IMM: shadow_regs[ra] = xy;
                        tcpu_pkg::OP_STORE: begin
                            if (xy == 8'h00) begin
                                res.out_valid = 1'b1;
                                res.out_byte  = shadow_regs[ra];
                            end else if (xy > win_start && xy < win_end) begin
                                clear_machine();
                                res.status = tcpu_pkg::STAT_PROTECTED;
                            end else begin
                                shadow_mem[xy] = shadow_regs[ra];
                            end
                        end
                        tcpu_pkg::OP_MOVE: shadow_regs[rt] = shadow_regs[rs];
                        tcpu_pkg::OP_ADD:
                            shadow_regs[ra] = 8'(shadow_regs[rs] + shadow_regs[rt]);
                        tcpu_pkg::OP_JUMP_EQ: begin
                            if (shadow_regs[ra] == shadow_regs[tcpu_pkg::REG_ZERO])
                                shadow_pc = xy;
                        end
                        tcpu_pkg::OP_HALT: begin
                            clear_machine();
                            res.status = tcpu_pkg::STAT_HALT;
                        end
                        default: begin
                            clear_machine();
                            res.status = tcpu_pkg::STAT_INVALID;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        res.pc_now    = shadow_pc;
        res.instr_now = word;
        return res;
    endfunction

    // Random instruction, weighted toward the supported opcodes
    function automatic logic [15:0] random_instr();
        logic [3:0] op;
        logic [3:0] ra;
        logic [7:0] xy;
        int pick;
        pick = $urandom_range(99);
        ra   = 4'($urandom_range(15));
        xy   = 8'($urandom_range(255));
        if (pick < 15) begin
            op = tcpu_pkg::OP_LOAD_MEM;
        end else if (pick < 35) begin
            op = tcpu_pkg::OP_LOAD_IMM;
        end else if (pick < 55) begin
            op = tcpu_pkg::OP_STORE;
            if ($urandom_range(2) == 0) xy = 8'h00;
        end else if (pick < 65) begin
            op = tcpu_pkg::OP_MOVE;
        end else if (pick < 80) begin
            op = tcpu_pkg::OP_ADD;
        end else if (pick < 90) begin
            op = tcpu_pkg::OP_JUMP_EQ;
            if ($urandom_range(1) == 1) xy = win_start + 8'(2 * $urandom_range(3));
        end else if (pick < 94) begin
            op = tcpu_pkg::OP_HALT;
        end else begin
            do op = 4'($urandom_range(15));
            while (op inside {tcpu_pkg::OP_LOAD_MEM, tcpu_pkg::OP_LOAD_IMM,
                              tcpu_pkg::OP_STORE, tcpu_pkg::OP_MOVE, tcpu_pkg::OP_ADD,
                              tcpu_pkg::OP_JUMP_EQ, tcpu_pkg::OP_HALT});
        end
        return {op, ra, xy};
    endfunction

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    // Offer one item, hold it until accepted, and record its expected step
    task automatic send_item(input logic [1:0] action, input logic [7:0] address,
                             input logic [7:0] data);
        tcpu_pkg::in_item_t item;
        item.action  = action;
        item.address = address;
        item.data    = data;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        step_results_due.push_back(cpu_step(item));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_bytes(input logic [7:0] base, input logic [7:0] bytes [$]);
        foreach (bytes[i]) send_item(tcpu_pkg::ACT_WRITE, base + 8'(i), bytes[i]);
    endtask

    task automatic send_exec();
        send_item(tcpu_pkg::ACT_EXEC, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // Drop valid and wait for every outstanding step to come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(negedge aclk);
        while (step_results_due.size() != 0);
    endtask

    // Reprogram the protection window; only done with the block idle
    task automatic set_program_window(input logic [7:0] lo, input logic [7:0] hi);
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= tcpu_pkg::CFG_PROG_START;
        cfg_wdata <= lo;
        @(negedge aclk);
        win_start = lo;
        cfg_index <= tcpu_pkg::CFG_PROG_END;
        cfg_wdata <= hi;
        @(negedge aclk);
        win_end = hi;
        cfg_wr_en <= 1'b0;
    endtask

    // Halt, seed some data, load a random program at the start and run it
    task automatic run_random_program(input int n_instr);
        logic [15:0] word;
        send_item(tcpu_pkg::ACT_HALT, 8'($urandom_range(255)), 8'($urandom_range(255)));
        repeat ($urandom_range(2))
            send_item(tcpu_pkg::ACT_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)));
        for (int i = 0; i < n_instr; i++) begin
            word = random_instr();
            send_item(tcpu_pkg::ACT_WRITE, win_start + 8'(2 * i), word[15:8]);
            send_item(tcpu_pkg::ACT_WRITE, win_start + 8'(2 * i + 1), word[7:0]);
        end
        repeat (n_instr + $urandom_range(3)) send_exec();
    endtask

    // Ignored action code, a write at the top of memory, execute on empty memory
    task automatic test_unused_and_empty();
        send_item(ACT_UNUSED, 8'hFF, 8'hFF);
        send_item(tcpu_pkg::ACT_WRITE, 8'hFF, 8'hFF);
        send_item(tcpu_pkg::ACT_EXEC, 8'h00, 8'h00);
    endtask

    // Straight-line program touching every supported operation but halt
    task automatic test_program_ops();
        logic [7:0] code [$];
        code = '{8'h2A, 8'hFF,    // RA = FF
                 8'h21, 8'h01,    // R1 = 01
                 8'h5B, 8'hA1,    // RB = RA + R1, wraps to 00
                 8'h3A, 8'h00,    // output RA
                 8'h1C, 8'h10,    // RC = mem[10]
                 8'h40, 8'hC3,    // R3 = RC
                 8'h33, 8'hF0,    // mem[F0] = R3
                 8'hB1, 8'h22,    // R1 differs from R0, falls through
                 8'hB0, 8'h24};   // always taken, lands on an empty word
        send_item(tcpu_pkg::ACT_HALT, 8'h00, 8'h00);
        write_bytes(win_start, code);
        repeat (10) send_exec();
    endtask

    // Protected store, invalid opcode, then program counter wrap at the top
    task automatic test_window_and_wrap();
        set_program_window(8'h30, 8'h40);
        send_item(tcpu_pkg::ACT_HALT, 8'h00, 8'h00);
        write_bytes(8'h30, '{8'h30, 8'h31});
        send_exec();
        write_bytes(8'h30, '{8'hF5, 8'h00});
        send_exec();
        set_program_window(8'hFF, 8'h00);
        send_item(tcpu_pkg::ACT_HALT, 8'h00, 8'h00);
        write_bytes(8'hFF, '{8'h22, 8'h7F, 8'hC0, 8'h00});
        send_exec();
        send_exec();
    endtask

    // Hold the output off while items keep coming so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = HOLD_CYCLES;
        run_random_program(6);
        run_random_program(4);
        wait_results_drained();
    endtask

    // Mostly random programs, some loose items, under one window and idle mix
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [7:0] lo, input logic [7:0] hi,
                                       input int quota);
        int stop_at;
        set_program_window(lo, hi);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                run_random_program($urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 5) wait_results_drained();
        end
        wait_results_drained();
    endtask

    // Receiver: random ready, or a long hold when one is requested
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each result with the oldest expected step
    always @(posedge aclk) begin : check_results
        tcpu_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (step_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_data);
                fail_count++;
            end else begin
                want = step_results_due.pop_front();
                checked_count++;
                if (want.out_valid) output_count++;
                if (want.status != tcpu_pkg::STAT_OK) fault_count++;
                check_field("out_valid", 32'(want.out_valid), 32'(m_data.out_valid));
                check_field("out_byte", 32'(want.out_byte), 32'(m_data.out_byte));
                check_field("status", 32'(want.status), 32'(m_data.status));
                check_field("pc_now", 32'(want.pc_now), 32'(m_data.pc_now));
                check_field("instr_now", 32'(want.instr_now), 32'(m_data.instr_now));
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = tcpu_pkg::CFG_PROG_START;
        cfg_wdata = 8'h00;
        s_valid   = 1'b0;
        s_data    = '0;
        win_start = tcpu_pkg::PROG_START_RST;
        win_end   = tcpu_pkg::PROG_END_RST;
        clear_machine();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_unused_and_empty();
        test_program_ops();
        test_window_and_wrap();
        test_backpressure();
        test_random_traffic(20, 56, 8'h10, 8'h30, 225);
        test_random_traffic(56, 20, 8'h00, 8'hFF, 225);
        test_random_traffic(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)), 225);

        wait_results_drained();
        repeat (20) @(posedge aclk);
        $display("covered %0d items over three idle mixes and six program windows",
                 items_sent);
        $display("checked %0d steps, %0d register outputs, %0d halts and faults",
                 checked_count, output_count, fault_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
